/* hdl/sensor_running_average_alarm_assert.svh */
// Assertion helpers for the RTL of the sensor alarm block.
`ifndef SENSOR_RUNNING_AVERAGE_ALARM_ASSERT_SVH
`define SENSOR_RUNNING_AVERAGE_ALARM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRAA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sensor alarm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRAA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sensor alarm assertion failed");

`endif

/* hdl/sraa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sraa_pkg;

  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_SAMPLE   = 1'b1;

  localparam logic CFG_MAX_TEMP = 1'b0;
  localparam logic CFG_MIN_TEMP = 1'b1;

  localparam logic signed [15:0] MAX_TEMP_RST = 16'sd2500;
  localparam logic signed [15:0] MIN_TEMP_RST = 16'sd1000;

  typedef enum logic [1:0] {
    ST_ACCEPTED   = 2'd0,
    ST_UNKNOWN    = 2'd1,
    ST_REGISTERED = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    AL_NONE = 2'd0,
    AL_HOT  = 2'd1,
    AL_COLD = 2'd2
  } alarm_t;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_RESOLVE = 6'b000100,
    S_SREAD   = 6'b001000,
    S_MUL     = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

endpackage

`default_nettype wire

/* hdl/sraa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM with one write port and one registered read port.
module sraa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/sensor_running_average_alarm.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_running_average_alarm_assert.svh"

// Moving-average temperature alarm for a table of registered sensors.
// Commands enter on start/busy: a beat is taken at a rising edge with start high and busy
// low, carrying in_cmd (register or sample), in_sensor_id and in_temperature. Every command
// produces exactly one result beat, shown for a single cycle with out_valid high; the
// receiver cannot stall it, so it must take the beat in that cycle.
// The limits are written on the cfg_ channel (index 0 hot limit, 1 cold limit); cfg_ready
// is always high and writes should only happen while the block is idle.
// Each sensor entry (id, ring position, valid bits, running sum) lives in one entry RAM and
// the samples in a second RAM. A command first scans the entry RAM, one entry per cycle,
// until the id matches or all registered entries are checked; with an empty table the
// scan is skipped. A register command then finishes in the resolve step and shows its
// result. An accepted sample adds a sample RAM read, the sum update and a two-stage
// divide by the window length. busy drops in the cycle the result is shown, so a new
// command can be taken then but not before; the scan through the single entry RAM read
// port makes a command take longer the more entries it must check.
// Reset empties the table and restores the default limits; no clearing pass is needed.
module sensor_running_average_alarm
  import sraa_pkg::*;
#(
  parameter int AVG_LEN     = 5,
  parameter int MAX_SENSORS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [15:0] in_sensor_id,
  input  wire logic signed [15:0] in_temperature,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [15:0]      out_sensor_id,
  output logic signed [15:0] out_average,
  output logic [1:0]       out_alarm,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Widths derived from the window length and table size.
  localparam int POS_W  = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
  localparam int LOG_D  = $clog2(AVG_LEN);
  localparam int SUM_W  = 17 + LOG_D;
  localparam int MAG_W  = SUM_W - 1;
  localparam int SH     = MAG_W + LOG_D;
  localparam int PROD_W = 2 * MAG_W + 1;
  // Rounded-up reciprocal: floor(x * MUL_C / 2^SH) equals floor(x / AVG_LEN) for x < 2^MAG_W.
  localparam longint unsigned MUL_C = ((64'd1 << SH) + AVG_LEN - 1) / AVG_LEN;
  localparam int EIDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CNT_W  = $clog2(MAX_SENSORS + 1);
  localparam int SLOTS  = MAX_SENSORS * AVG_LEN;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic [15:0]              id;
    logic [POS_W-1:0]         pos;
    logic [AVG_LEN-1:0]       mask;
    logic signed [SUM_W-1:0]  sum;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  // Control registers.
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] max_temp_r, max_temp_nxt;
  logic signed [15:0] min_temp_r, min_temp_nxt;

  // Payload registers.
  logic               cmd_r, cmd_nxt;
  logic [15:0]        id_r, id_nxt;
  logic signed [15:0] temp_r, temp_nxt;
  logic               found_r, found_nxt;
  logic [EIDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [EIDX_W-1:0]  entry_r, entry_nxt;
  entry_t             rec_r, rec_nxt;
  logic [POS_W-1:0]   wpos_r, wpos_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic               neg_r, neg_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [15:0]        out_id_r, out_id_nxt;
  logic signed [15:0] out_average_r, out_average_nxt;
  alarm_t             out_alarm_r, out_alarm_nxt;

  // RAM ports.
  logic               ent_we;
  logic [EIDX_W-1:0]  ent_waddr, ent_raddr;
  entry_t             ent_wdata, ent_rd;
  logic [ENT_W-1:0]   ent_rdata;
  logic               smp_we;
  logic [SLOT_W-1:0]  smp_raddr;
  logic [15:0]        smp_rdata;

  logic               accept;
  logic               scan_last;
  logic [POS_W-1:0]   pos_adv;
  logic signed [SUM_W-1:0] old_ext, temp_ext, sum_new, mag_full;
  logic [15:0]        quot;
  logic signed [15:0] avg_c;

  sraa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SENSORS)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  sraa_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_sample_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (slot_r),
    .wdata (temp_r),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  assign ent_rd    = entry_t'(ent_rdata);
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // The scan is over once the entry just read is the last one in use.
  assign scan_last = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r);

  // Ring position after this sample, wrapping at the window length.
  assign pos_adv = (rec_r.pos == POS_W'(AVG_LEN - 1)) ? '0 : rec_r.pos + POS_W'(1);

  // Running sum update: drop the sample being overwritten if that slot held one.
  assign old_ext  = rec_r.mask[wpos_r] ? {{(SUM_W-16){smp_rdata[15]}}, smp_rdata} : '0;
  assign temp_ext = {{(SUM_W-16){temp_r[15]}}, temp_r};
  assign sum_new  = rec_r.sum - old_ext + temp_ext;

  // Divide by the window length on the magnitude, then restore the sign (truncates toward 0).
  assign mag_full = sum_r[SUM_W-1] ? -sum_r : sum_r;
  assign quot     = prod_r[SH +: 16];
  assign avg_c    = neg_r ? -quot : quot;

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    out_valid_nxt   = 1'b0;
    max_temp_nxt    = max_temp_r;
    min_temp_nxt    = min_temp_r;
    cmd_nxt         = cmd_r;
    id_nxt          = id_r;
    temp_nxt        = temp_r;
    found_nxt       = found_r;
    scan_idx_nxt    = scan_idx_r;
    entry_nxt       = entry_r;
    rec_nxt         = rec_r;
    wpos_nxt        = wpos_r;
    slot_nxt        = slot_r;
    sum_nxt         = sum_r;
    neg_nxt         = neg_r;
    prod_nxt        = prod_r;
    out_status_nxt  = out_status_r;
    out_id_nxt      = out_id_r;
    out_average_nxt = out_average_r;
    out_alarm_nxt   = out_alarm_r;
    ent_we          = 1'b0;
    ent_waddr       = entry_r;
    ent_wdata       = '{id: id_r, pos: '0, mask: '0, sum: '0};
    ent_raddr       = '0;
    smp_we          = 1'b0;
    smp_raddr       = slot_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_TEMP: max_temp_nxt = cfg_data;
        CFG_MIN_TEMP: min_temp_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt      = in_cmd;
          id_nxt       = in_sensor_id;
          temp_nxt     = in_temperature;
          found_nxt    = 1'b0;
          scan_idx_nxt = '0;
          state_nxt    = (count_r == '0) ? S_RESOLVE : S_SCAN;
        end
      end
      S_SCAN: begin
        // Read data belongs to scan_idx_r; the next entry is fetched speculatively.
        ent_raddr = scan_idx_r + EIDX_W'(1);
        if (ent_rd.id == id_r) begin
          found_nxt = 1'b1;
          entry_nxt = scan_idx_r;
          rec_nxt   = ent_rd;
          state_nxt = S_RESOLVE;
        end else if (scan_last) begin
          state_nxt = S_RESOLVE;
        end else begin
          scan_idx_nxt = scan_idx_r + EIDX_W'(1);
        end
      end
      S_RESOLVE: begin
        out_id_nxt      = id_r;
        out_average_nxt = '0;
        out_alarm_nxt   = AL_NONE;
        if (cmd_r == CMD_REGISTER) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (found_r) begin
            // Known id: empty its window again.
            ent_we         = 1'b1;
            out_status_nxt = ST_REGISTERED;
          end else if (count_r < CNT_W'(MAX_SENSORS)) begin
            ent_we         = 1'b1;
            ent_waddr      = count_r[EIDX_W-1:0];
            count_nxt      = count_r + CNT_W'(1);
            out_status_nxt = ST_REGISTERED;
          end else begin
            out_status_nxt = ST_FULL;
          end
        end else if (!found_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_UNKNOWN;
          state_nxt      = S_IDLE;
        end else begin
          wpos_nxt  = pos_adv;
          slot_nxt  = SLOT_W'(entry_r) * SLOT_W'(AVG_LEN) + SLOT_W'(pos_adv);
          smp_raddr = slot_nxt;
          state_nxt = S_SREAD;
        end
      end
      S_SREAD: begin
        ent_we    = 1'b1;
        ent_wdata = '{id: id_r, pos: wpos_r,
                      mask: rec_r.mask | (AVG_LEN'(1) << wpos_r), sum: sum_new};
        smp_we    = 1'b1;
        sum_nxt   = sum_new;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        neg_nxt   = sum_r[SUM_W-1];
        prod_nxt  = PROD_W'(mag_full[MAG_W-1:0]) * PROD_W'(MUL_C);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        out_valid_nxt   = 1'b1;
        out_status_nxt  = ST_ACCEPTED;
        out_average_nxt = avg_c;
        // The hot limit wins when both limits are crossed.
        if (avg_c > max_temp_r) begin
          out_alarm_nxt = AL_HOT;
        end else if (avg_c < min_temp_r) begin
          out_alarm_nxt = AL_COLD;
        end else begin
          out_alarm_nxt = AL_NONE;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      max_temp_r  <= MAX_TEMP_RST;
      min_temp_r  <= MIN_TEMP_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      max_temp_r  <= max_temp_nxt;
      min_temp_r  <= min_temp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    id_r          <= id_nxt;
    temp_r        <= temp_nxt;
    found_r       <= found_nxt;
    scan_idx_r    <= scan_idx_nxt;
    entry_r       <= entry_nxt;
    rec_r         <= rec_nxt;
    wpos_r        <= wpos_nxt;
    slot_r        <= slot_nxt;
    sum_r         <= sum_nxt;
    neg_r         <= neg_nxt;
    prod_r        <= prod_nxt;
    out_status_r  <= out_status_nxt;
    out_id_r      <= out_id_nxt;
    out_average_r <= out_average_nxt;
    out_alarm_r   <= out_alarm_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_sensor_id = out_id_r;
  assign out_average   = out_average_r;
  assign out_alarm     = out_alarm_r;

  // A result beat is only shown once the command has fully retired.
  `SRAA_ASSERT_IMPL(a_result_idle, clk, rst_n, out_valid_r, state_r == S_IDLE)
  // A taken command always leaves the idle state on the next cycle.
  `SRAA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // The table never grows past its size.
  `SRAA_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, int'(count_r) <= MAX_SENSORS)
  // The sample slot address stays inside the sample RAM.
  `SRAA_ASSERT_IMPL(a_slot_bound, clk, rst_n, state_r == S_SREAD, int'(slot_r) < SLOTS)
  // Only an accepted sample carries an average or an alarm.
  `SRAA_ASSERT_IMPL(a_drop_zero, clk, rst_n, out_valid_r && out_status_r != ST_ACCEPTED, out_average_r == '0 && out_alarm_r == AL_NONE)

endmodule

`default_nettype wire
